// File: rtl/core/aht_pkg.sv
// Package for the annotation hit test core: widths, field offsets, shape and
// register codes, and the command/status structs between controller and datapath.
// No dependencies.
package aht_pkg;

	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int DIST_BITS  = 32;
	localparam int ID_BITS    = 32;
	localparam int SHAPE_BITS = 3;
	localparam int CNT_BITS   = 16;

	// magnitude of a coordinate difference, products and sums of three squares
	localparam int MAG_BITS   = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * MAG_BITS;
	localparam int SUM_BITS   = PROD_BITS + 2;
	localparam int DIFF_BITS  = COORD_BITS + 3;
	localparam int ROOT_BITS  = SUM_BITS / 2;
	localparam int T_BITS     = FRAC_BITS + 1;
	localparam int ITER_BITS  = $clog2(ROOT_BITS + 1);

	localparam int CFG_BITS   = (COORD_BITS > DIST_BITS) ? COORD_BITS : DIST_BITS;
	localparam int IDX_BITS   = 2;

	// input tdata layout, lowest bit first
	localparam int ID_LSB      = 0;
	localparam int SHAPE_LSB   = ID_LSB + ID_BITS;
	localparam int RAD_LSB     = SHAPE_LSB + SHAPE_BITS;
	localparam int VIS_LSB     = RAD_LSB + DIST_BITS;
	localparam int X_LSB       = VIS_LSB + 1;
	localparam int Y_LSB       = X_LSB + COORD_BITS;
	localparam int Z_LSB       = Y_LSB + COORD_BITS;
	localparam int IN_USED     = Z_LSB + COORD_BITS;
	localparam int IN_TDATA_BITS  = ((IN_USED + 7) / 8) * 8;
	localparam int OUT_USED       = 1 + ID_BITS + DIST_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_USED + 7) / 8) * 8;

	localparam logic [SHAPE_BITS-1:0] SHAPE_CIRCLE = 3'd1;
	localparam logic [SHAPE_BITS-1:0] SHAPE_TEXT   = 3'd2;
	localparam logic [SHAPE_BITS-1:0] SHAPE_LINE   = 3'd3;
	localparam logic [SHAPE_BITS-1:0] SHAPE_RECT   = 3'd6;

	localparam logic [IDX_BITS-1:0] REG_QUERY_X   = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_QUERY_Y   = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_QUERY_Z   = 2'd2;
	localparam logic [IDX_BITS-1:0] REG_TOLERANCE = 2'd3;

	typedef enum logic [1:0] {
		LD_NONE      = 2'd0,
		LD_POINT     = 2'd1,
		LD_PREV_CUR  = 2'd2,
		LD_CUR_FIRST = 2'd3
	} load_sel_t;

	typedef enum logic [1:0] {
		DST_LEN  = 2'd0,
		DST_DOT  = 2'd1,
		DST_PROJ = 2'd2,
		DST_SQ   = 2'd3
	} mul_dst_t;

	typedef struct packed {
		logic      latch;
		logic      set_first;
		load_sel_t load_sel;
		logic      circle;
		logic      mul_go;
		mul_dst_t  mul_dst;
		logic [1:0] axis;
		logic      t_init;
		logic      div_step;
		logic      sqrt_init;
		logic      sqrt_step;
		logic      post;
		logic      advance;
		logic      decide;
		logic      report;
	} dp_cmd_t;

	typedef struct packed {
		logic                  finish;
		logic [SHAPE_BITS-1:0] shape;
		logic                  last;
		logic                  cnt_zero;
		logic                  cnt_ge2;
		logic                  out_full;
	} dp_stat_t;

endpackage

// File: rtl/core/aht_dp.sv
// Datapath of the annotation hit test core: configuration registers, vertex
// state, shared multiplier, divide and square-root iterations, output register.
// Depends on aht_pkg.
module aht_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [aht_pkg::IDX_BITS-1:0]       cfg_index,
	input  logic [aht_pkg::CFG_BITS-1:0]       cfg_data,
	input  logic [aht_pkg::IN_TDATA_BITS-1:0]  s_tdata,
	input  logic                               s_tuser,
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [aht_pkg::OUT_TDATA_BITS-1:0] m_tdata,
	input  aht_pkg::dp_cmd_t                   cmd,
	output aht_pkg::dp_stat_t                  stat
);

	localparam int C = aht_pkg::COORD_BITS;
	localparam int D = aht_pkg::DIST_BITS;
	localparam int F = aht_pkg::FRAC_BITS;
	localparam int M = aht_pkg::MAG_BITS;
	localparam int P = aht_pkg::PROD_BITS;
	localparam int S = aht_pkg::SUM_BITS;
	localparam int W = aht_pkg::DIFF_BITS;
	localparam int R = aht_pkg::ROOT_BITS;
	localparam int T = aht_pkg::T_BITS;
	localparam logic [D-1:0] DIST_ONES = {D{1'b1}};

	typedef logic signed [C-1:0] coord_t;

	coord_t q_q [3];
	logic [D-1:0] tol_q;

	logic                              finish_q, last_q, vis_q;
	logic [aht_pkg::ID_BITS-1:0]       id_q;
	logic [aht_pkg::SHAPE_BITS-1:0]    shape_q;
	logic [D-1:0]                      radius_q;
	coord_t v_q [3];
	coord_t first_q [3];
	coord_t prev_q [3];
	coord_t a_q [3];
	coord_t b_q [3];
	logic                              circle_q;
	logic [aht_pkg::CNT_BITS-1:0]      count_q;
	logic [D-1:0]                      amin_q, best_q;
	logic [aht_pkg::ID_BITS-1:0]       owner_q;

	logic [P-1:0]            prod_s1;
	logic                    neg_s1, vld_s1;
	aht_pkg::mul_dst_t       dst_s1;
	logic [1:0]              axis_s1;

	logic [S-1:0]            len2_q, ssum_q, rem_q, rad_q;
	logic signed [S-1:0]     dot_q;
	logic [T-1:0]            t_q;
	logic                    div_on_q;
	logic signed [W-1:0]     d_q [3];
	logic [R-1:0]            root_q;
	logic [R+1:0]            srem_q;

	logic                    out_full_q;
	logic [aht_pkg::OUT_USED-1:0] out_q;

	function automatic logic [M-1:0] mag(input logic signed [W-1:0] v);
		logic signed [W-1:0] n;
		n = v[W-1] ? -v : v;
		return n[M-1:0];
	endfunction

	// operands of the selected axis
	logic [1:0]          k;
	logic signed [W-1:0] ab, ap;
	logic [M-1:0]        mx, my;
	logic                mneg;

	assign k = (cmd.axis == 2'd3) ? 2'd2 : cmd.axis;

	always_comb begin
		ab = W'(b_q[k]) - W'(a_q[k]);
		ap = W'(q_q[k]) - W'(a_q[k]);
		mx = mag(ab);
		my = mag(ab);
		mneg = 1'b0;
		case (cmd.mul_dst)
			aht_pkg::DST_LEN: begin
				mneg = 1'b0;
			end
			aht_pkg::DST_DOT: begin
				mx = mag(ap);
				mneg = ap[W-1] ^ ab[W-1];
			end
			aht_pkg::DST_PROJ: begin
				my = M'(t_q);
				mneg = ab[W-1];
			end
			aht_pkg::DST_SQ: begin
				mx = mag(d_q[k]);
				my = mag(d_q[k]);
			end
			default: begin
				mneg = 1'b0;
			end
		endcase
	end

	// accumulate side
	logic signed [S-1:0] prod_ext, sprod, sshift;
	logic signed [W-1:0] aq;
	logic [1:0]          k1;

	assign k1 = (axis_s1 == 2'd3) ? 2'd2 : axis_s1;

	always_comb begin
		prod_ext = $signed(S'(prod_s1));
		sprod = neg_s1 ? -prod_ext : prod_ext;
		sshift = sprod >>> F;
		aq = W'(a_q[k1]) - W'(q_q[k1]);
	end

	// division and square-root steps
	logic [S-1:0]   rem2;
	logic [R+3:0]   scur, strial;
	logic [R-1:0]   pfull;
	logic [D-1:0]   pdist;

	always_comb begin
		rem2 = {rem_q[S-2:0], 1'b0};
		scur = {srem_q, rad_q[S-1:S-2]};
		strial = (R+4)'({root_q, 2'b01});
		pfull = root_q;
		if (circle_q) begin
			pfull = (root_q >= R'(radius_q)) ? root_q - R'(radius_q) : R'(radius_q) - root_q;
		end
		pdist = (pfull > R'(DIST_ONES)) ? DIST_ONES : pfull[D-1:0];
	end

	logic dot_pos, dot_ge;
	assign dot_pos = !dot_q[S-1] && (dot_q != '0);
	assign dot_ge  = dot_q >= $signed(len2_q);

	always_ff @(posedge clk) begin
		prod_s1 <= mx * my;
		neg_s1  <= mneg;
		dst_s1  <= cmd.mul_dst;
		axis_s1 <= cmd.axis;

		if (cmd.latch) begin
			id_q     <= s_tdata[aht_pkg::ID_LSB +: aht_pkg::ID_BITS];
			shape_q  <= s_tdata[aht_pkg::SHAPE_LSB +: aht_pkg::SHAPE_BITS];
			radius_q <= s_tdata[aht_pkg::RAD_LSB +: D];
			vis_q    <= s_tdata[aht_pkg::VIS_LSB];
			v_q[0]   <= s_tdata[aht_pkg::X_LSB +: C];
			v_q[1]   <= s_tdata[aht_pkg::Y_LSB +: C];
			v_q[2]   <= s_tdata[aht_pkg::Z_LSB +: C];
			last_q   <= s_tlast;
			finish_q <= s_tuser;
		end
		if (cmd.set_first) first_q <= v_q;
		if (cmd.load_sel != aht_pkg::LD_NONE) begin
			circle_q <= cmd.circle;
			len2_q <= '0;
			dot_q  <= '0;
			ssum_q <= '0;
		end
		case (cmd.load_sel)
			aht_pkg::LD_POINT: begin
				a_q <= v_q;
				b_q <= v_q;
			end
			aht_pkg::LD_PREV_CUR: begin
				a_q <= prev_q;
				b_q <= v_q;
			end
			aht_pkg::LD_CUR_FIRST: begin
				a_q <= v_q;
				b_q <= first_q;
			end
			default: begin
			end
		endcase
		if (vld_s1) begin
			case (dst_s1)
				aht_pkg::DST_LEN:  len2_q <= len2_q + S'(prod_s1);
				aht_pkg::DST_DOT:  dot_q <= dot_q + sprod;
				aht_pkg::DST_PROJ: d_q[k1] <= aq + W'(sshift);
				aht_pkg::DST_SQ:   ssum_q <= ssum_q + S'(prod_s1);
				default: begin
				end
			endcase
		end
		if (cmd.t_init) begin
			t_q      <= (len2_q != '0 && dot_pos && dot_ge) ? T'(1) << F : '0;
			div_on_q <= len2_q != '0 && dot_pos && !dot_ge;
			rem_q    <= dot_q;
		end
		if (cmd.div_step && div_on_q) begin
			if (rem2 >= len2_q) begin
				rem_q <= rem2 - len2_q;
				t_q   <= {t_q[T-2:0], 1'b1};
			end else begin
				rem_q <= rem2;
				t_q   <= {t_q[T-2:0], 1'b0};
			end
		end
		if (cmd.sqrt_init) begin
			rad_q  <= ssum_q;
			root_q <= '0;
			srem_q <= '0;
		end
		if (cmd.sqrt_step) begin
			rad_q <= {rad_q[S-3:0], 2'b00};
			if (scur >= strial) begin
				srem_q <= (R+2)'(scur - strial);
				root_q <= {root_q[R-2:0], 1'b1};
			end else begin
				srem_q <= (R+2)'(scur);
				root_q <= {root_q[R-2:0], 1'b0};
			end
		end
		if (cmd.advance) prev_q <= v_q;
		if (cmd.report) out_q <= {best_q, owner_q, best_q != DIST_ONES};
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q[0] <= '0;
			q_q[1] <= '0;
			q_q[2] <= '0;
			tol_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				aht_pkg::REG_QUERY_X:   q_q[0] <= cfg_data[C-1:0];
				aht_pkg::REG_QUERY_Y:   q_q[1] <= cfg_data[C-1:0];
				aht_pkg::REG_QUERY_Z:   q_q[2] <= cfg_data[C-1:0];
				aht_pkg::REG_TOLERANCE: tol_q <= cfg_data[D-1:0];
				default: begin
				end
			endcase
		end
	end

	// control state and search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			count_q    <= '0;
			amin_q     <= DIST_ONES;
			best_q     <= DIST_ONES;
			owner_q    <= '0;
			out_full_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.mul_go;
			if (cmd.post && pdist < amin_q) amin_q <= pdist;
			if (cmd.advance && count_q != '1) count_q <= count_q + 1'b1;
			if (cmd.decide) begin
				if (vis_q && amin_q < tol_q && amin_q < best_q) begin
					best_q  <= amin_q;
					owner_q <= id_q;
				end
				count_q <= '0;
				amin_q  <= DIST_ONES;
			end
			if (cmd.report) begin
				out_full_q <= 1'b1;
				best_q  <= DIST_ONES;
				owner_q <= '0;
				count_q <= '0;
				amin_q  <= DIST_ONES;
			end else if (m_tready) begin
				out_full_q <= 1'b0;
			end
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_full_q;
	assign m_tdata   = aht_pkg::OUT_TDATA_BITS'(out_q);

	assign stat.finish   = finish_q;
	assign stat.shape    = shape_q;
	assign stat.last     = last_q;
	assign stat.cnt_zero = count_q == '0;
	assign stat.cnt_ge2  = count_q >= aht_pkg::CNT_BITS'(2);
	assign stat.out_full = out_full_q;

endmodule

// File: rtl/core/aht_ctrl.sv
// Controller of the annotation hit test core: sequences each distance job
// through the shared multiplier, divider and square-root steps.
// Depends on aht_pkg.
module aht_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  aht_pkg::dp_stat_t  stat,
	output aht_pkg::dp_cmd_t   cmd
);

	localparam int IB = aht_pkg::ITER_BITS;

	typedef enum logic [14:0] {
		ST_IDLE    = 15'h0001,
		ST_DECODE  = 15'h0002,
		ST_LEN     = 15'h0004,
		ST_DOT     = 15'h0008,
		ST_TINIT   = 15'h0010,
		ST_DIV     = 15'h0020,
		ST_PROJ    = 15'h0040,
		ST_SQ      = 15'h0080,
		ST_SQINIT  = 15'h0100,
		ST_SQRT    = 15'h0200,
		ST_POST    = 15'h0400,
		ST_ADVANCE = 15'h0800,
		ST_CLOSE   = 15'h1000,
		ST_FINAL   = 15'h2000,
		ST_REPORT  = 15'h4000
	} state_t;

	state_t state_q, state_d;
	logic [IB-1:0] iter_q, iter_d;
	logic closing_q, closing_d;
	logic mul_end;

	assign mul_end  = iter_q == IB'(3);
	assign s_tready = state_q == ST_IDLE;

	always_comb begin
		state_d   = state_q;
		iter_d    = iter_q;
		closing_d = closing_q;
		cmd = '0;
		cmd.axis = iter_q[1:0];
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				iter_d = '0;
				closing_d = 1'b0;
				if (stat.finish) begin
					state_d = ST_REPORT;
				end else if (stat.cnt_zero) begin
					cmd.set_first = 1'b1;
					if (stat.shape <= aht_pkg::SHAPE_TEXT) begin
						cmd.load_sel = aht_pkg::LD_POINT;
						cmd.circle = stat.shape == aht_pkg::SHAPE_CIRCLE;
						state_d = ST_LEN;
					end else begin
						state_d = ST_ADVANCE;
					end
				end else if (stat.shape >= aht_pkg::SHAPE_LINE) begin
					cmd.load_sel = aht_pkg::LD_PREV_CUR;
					state_d = ST_LEN;
				end else begin
					state_d = ST_ADVANCE;
				end
			end
			ST_LEN: begin
				cmd.mul_go = !mul_end;
				cmd.mul_dst = aht_pkg::DST_LEN;
				iter_d = iter_q + 1'b1;
				if (mul_end) begin
					iter_d = '0;
					state_d = ST_DOT;
				end
			end
			ST_DOT: begin
				cmd.mul_go = !mul_end;
				cmd.mul_dst = aht_pkg::DST_DOT;
				iter_d = iter_q + 1'b1;
				if (mul_end) begin
					iter_d = '0;
					state_d = ST_TINIT;
				end
			end
			ST_TINIT: begin
				cmd.t_init = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				iter_d = iter_q + 1'b1;
				if (iter_q == IB'(aht_pkg::FRAC_BITS - 1)) begin
					iter_d = '0;
					state_d = ST_PROJ;
				end
			end
			ST_PROJ: begin
				cmd.mul_go = !mul_end;
				cmd.mul_dst = aht_pkg::DST_PROJ;
				iter_d = iter_q + 1'b1;
				if (mul_end) begin
					iter_d = '0;
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				cmd.mul_go = !mul_end;
				cmd.mul_dst = aht_pkg::DST_SQ;
				iter_d = iter_q + 1'b1;
				if (mul_end) begin
					iter_d = '0;
					state_d = ST_SQINIT;
				end
			end
			ST_SQINIT: begin
				cmd.sqrt_init = 1'b1;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				iter_d = iter_q + 1'b1;
				if (iter_q == IB'(aht_pkg::ROOT_BITS - 1)) begin
					iter_d = '0;
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				cmd.post = 1'b1;
				state_d = closing_q ? ST_FINAL : ST_ADVANCE;
			end
			ST_ADVANCE: begin
				cmd.advance = 1'b1;
				state_d = stat.last ? ST_CLOSE : ST_IDLE;
			end
			ST_CLOSE: begin
				// closing segment back to the first vertex
				if (stat.shape >= aht_pkg::SHAPE_RECT && stat.cnt_ge2) begin
					cmd.load_sel = aht_pkg::LD_CUR_FIRST;
					closing_d = 1'b1;
					iter_d = '0;
					state_d = ST_LEN;
				end else begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				cmd.decide = 1'b1;
				state_d = ST_IDLE;
			end
			ST_REPORT: begin
				if (!stat.out_full) begin
					cmd.report = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			iter_q    <= '0;
			closing_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			iter_q    <= iter_d;
			closing_q <= closing_d;
		end
	end

endmodule

// File: rtl/core/annotation_hit_test_core.sv
// Top level of the annotation hit test core: joins controller and datapath.
// Depends on aht_pkg, aht_ctrl and aht_dp.
//
// Usage: write query_x/y/z (index 0..2) and hit_tolerance (index 3) on the
// cfg channel while the core is idle; cfg_ready is always high.
// Stream annotations on the s_ channel, one vertex per transaction, tlast on
// the final vertex of each annotation, tuser = 0. A transaction with tuser = 1
// ends the query: one result appears on the m_ channel with hit flag, id and
// distance of the nearest visible annotation under tolerance; search cleared.
// Timing: s_tready is high only while the core is idle. A distance job makes
// four passes of three multiplies on the shared 33x33 multiplier, 16 divide
// steps and 34 square-root steps. The next vertex is taken only once the jobs
// of the current one are done; a closing rectangle or polygon edge adds a
// second job. A finish passes the DECODE and REPORT states and then posts its
// result into the output register; REPORT waits while that register is full.
// The output register lets further vertices be processed while a result
// waits; a following finish holds in the core until m_tready drains it.
// Reset clears the search state, the configuration registers and the output valid flag.
module annotation_hit_test_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [aht_pkg::IDX_BITS-1:0]       cfg_index,
	input  logic [aht_pkg::CFG_BITS-1:0]       cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// annot_id, shape_type, circle_radius, is_visible, x_coord, y_coord, z_coord
	input  logic [aht_pkg::IN_TDATA_BITS-1:0]  s_tdata,
	// opcode
	input  logic                               s_tuser,
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// hit_found, best_id, best_distance
	output logic [aht_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

	aht_pkg::dp_cmd_t  cmd;
	aht_pkg::dp_stat_t stat;

	aht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	aht_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// File: sim/tb_annotation_hit_test_core.sv
// Self-checking testbench for annotation_hit_test_core: a bit-exact predictor of
// the nearest-hit search checks every report on the m_ stream.
// Depends on aht_pkg and the RTL of the core.
module tb_annotation_hit_test_core;
	timeunit 1ns;
	timeprecision 1ps;
	import aht_pkg::*;

	localparam logic [SHAPE_BITS-1:0] SHAPE_POINT    = 3'd0;
	localparam logic [SHAPE_BITS-1:0] SHAPE_POLYLINE = 3'd4;
	localparam logic [SHAPE_BITS-1:0] SHAPE_FREEHAND = 3'd5;
	localparam logic [SHAPE_BITS-1:0] SHAPE_POLYGON  = 3'd7;
	localparam logic OP_VERTEX = 1'b0;
	localparam logic OP_FINISH = 1'b1;
	localparam int   U = 65536;
	localparam int   SETTLE_CYCLES = 250;
	localparam int   HOLD_CYCLES = 3000;
	localparam logic [31:0] DIST_NONE = 32'hFFFF_FFFF;

	typedef logic [63:0] word_t;
	typedef word_t vec3_t [3];
	typedef struct packed {
		logic        hit;
		logic [31:0] id;
		logic [31:0] distance;
	} report_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;
	logic s_tvalid, s_tready, s_tuser, s_tlast;
	logic [IN_TDATA_BITS-1:0] s_tdata;
	logic m_tvalid, m_tready;
	logic [OUT_TDATA_BITS-1:0] m_tdata;

	annotation_hit_test_core dut (.*);

	// predictor state
	word_t       qry [3];
	logic [31:0] tol;
	vec3_t       first_v, prev_v;
	logic [15:0] vcount;
	logic [31:0] ann_min, lead_distance, best_id;

	report_t pending_reports [$];
	int n_sent, n_reports, n_errors, n_hits;
	bit src_gap_en, sink_stall_en, hold_req;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic word_t sx32(logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic word_t mag64(word_t v);
		return v[63] ? -v : v;
	endfunction

	function automatic word_t norm_root(word_t d0, word_t d1, word_t d2);
		logic [127:0] s, m0, m1, m2;
		word_t res, cand;
		m0 = {64'd0, mag64(d0)};
		m1 = {64'd0, mag64(d1)};
		m2 = {64'd0, mag64(d2)};
		s = m0 * m0 + m1 * m1 + m2 * m2;
		res = '0;
		for (int b = 63; b >= 0; b--) begin
			cand = res | (word_t'(1) << b);
			if ({64'd0, cand} * {64'd0, cand} <= s)
				res = cand;
		end
		return res;
	endfunction

	function automatic logic [31:0] sat_dist(word_t v);
		return (v > {32'd0, DIST_NONE}) ? DIST_NONE : v[31:0];
	endfunction

	function automatic logic [31:0] norm_sat(word_t d0, word_t d1, word_t d2);
		return sat_dist(norm_root(d0, d1, d2));
	endfunction

	function automatic logic [31:0] seg_distance(vec3_t a, vec3_t b);
		word_t ab [3], ap [3], d [3], t;
		logic [127:0] len2, num;
		logic signed [127:0] dot, p;
		len2 = '0;
		dot = '0;
		t = '0;
		for (int k = 0; k < 3; k++) begin
			ab[k] = b[k] - a[k];
			ap[k] = qry[k] - a[k];
			len2 += {64'd0, mag64(ab[k])} * {64'd0, mag64(ab[k])};
			dot += $signed({{64{ap[k][63]}}, ap[k]}) * $signed({{64{ab[k][63]}}, ab[k]});
		end
		// clamp the projection to [0,1]
		if (len2 != 0 && dot > 0) begin
			if (128'(dot) >= len2)
				t = word_t'(1) << FRAC_BITS;
			else begin
				num = 128'(dot) << FRAC_BITS;
				t = word_t'(num / len2);
			end
		end
		for (int k = 0; k < 3; k++) begin
			p = $signed({{64{ab[k][63]}}, ab[k]}) * $signed({64'd0, t});
			p = p >>> FRAC_BITS;
			d[k] = a[k] - qry[k] + p[63:0];
		end
		return norm_sat(d[0], d[1], d[2]);
	endfunction

	function automatic void keep_nearer(logic [31:0] d);
		if (d < ann_min)
			ann_min = d;
	endfunction

	function automatic void predict_search(logic op, logic [31:0] id, logic [2:0] shape,
			logic [31:0] rad, logic vis, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic last);
		vec3_t v;
		word_t root;
		report_t r;
		if (op == OP_FINISH) begin
			r.hit = lead_distance != DIST_NONE;
			r.id = best_id;
			r.distance = lead_distance;
			pending_reports.push_back(r);
			lead_distance = DIST_NONE;
			best_id = '0;
			vcount = '0;
			ann_min = DIST_NONE;
			return;
		end
		v[0] = sx32(x);
		v[1] = sx32(y);
		v[2] = sx32(z);
		if (vcount == 0) begin
			first_v = v;
			if (shape <= SHAPE_TEXT) begin
				// circle offset is taken before saturation
				root = norm_root(qry[0] - v[0], qry[1] - v[1], qry[2] - v[2]);
				if (shape == SHAPE_CIRCLE)
					root = (root >= {32'd0, rad}) ? root - {32'd0, rad} :
						{32'd0, rad} - root;
				keep_nearer(sat_dist(root));
			end
		end else if (shape >= SHAPE_LINE) begin
			keep_nearer(seg_distance(prev_v, v));
		end
		prev_v = v;
		if (vcount != 16'hFFFF)
			vcount++;
		if (last) begin
			if (shape >= SHAPE_RECT && vcount >= 2)
				keep_nearer(seg_distance(v, first_v));
			if (vis && ann_min < tol && ann_min < lead_distance) begin
				lead_distance = ann_min;
				best_id = id;
			end
			vcount = '0;
			ann_min = DIST_NONE;
		end
	endfunction

	task automatic send_item(logic op, logic [31:0] id, logic [2:0] shape, logic [31:0] rad,
			logic vis, logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
		logic [IN_TDATA_BITS-1:0] td;
		int gap;
		td = '0;
		td[ID_LSB +: ID_BITS] = id;
		td[SHAPE_LSB +: SHAPE_BITS] = shape;
		td[RAD_LSB +: DIST_BITS] = rad;
		td[VIS_LSB] = vis;
		td[X_LSB +: COORD_BITS] = x;
		td[Y_LSB +: COORD_BITS] = y;
		td[Z_LSB +: COORD_BITS] = z;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = td;
		s_tuser = op;
		s_tlast = last;
		do @(posedge clk); while (!s_tready);
		predict_search(op, id, shape, rad, vis, x, y, z, last);
		n_sent++;
		if (src_gap_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_vertex(logic [31:0] id, logic [2:0] shape, logic vis,
			int x, int y, int z, logic last, logic [31:0] rad = 0);
		send_item(OP_VERTEX, id, shape, rad, vis, x, y, z, last);
	endtask

	task automatic send_finish();
		send_item(OP_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom);
	endtask

	task automatic drop_stream();
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// wait until every report is in, then let a pending distance job finish
	task automatic wait_idle();
		drop_stream();
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_QUERY_X: qry[0] = sx32(val);
			REG_QUERY_Y: qry[1] = sx32(val);
			REG_QUERY_Z: qry[2] = sx32(val);
			REG_TOLERANCE: tol = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_query(int x, int y, int z, logic [31:0] t);
		write_reg(REG_QUERY_X, x);
		write_reg(REG_QUERY_Y, y);
		write_reg(REG_QUERY_Z, z);
		write_reg(REG_TOLERANCE, t);
	endtask

	task automatic test_shapes();
		set_query(0, 0, 0, 100 * U);
		send_vertex(10, SHAPE_POINT, 1, 3 * U, 4 * U, 0, 1);
		send_vertex(11, SHAPE_CIRCLE, 1, 10 * U, 0, 0, 1, 9 * U);
		send_vertex(12, SHAPE_TEXT, 0, 0, 0, U, 1);
		send_vertex(13, SHAPE_LINE, 1, 0, 0, 0, 1);
		send_vertex(14, SHAPE_LINE, 1, -5 * U, U / 2, 0, 0);
		send_vertex(14, SHAPE_LINE, 1, 5 * U, U / 2, 7, 1);
		send_finish();
		send_vertex(20, SHAPE_POLYLINE, 1, 2 * U, 2 * U, 2 * U, 0);
		send_vertex(20, SHAPE_POLYLINE, 1, 2 * U, 2 * U, 2 * U, 0);
		send_vertex(20, SHAPE_POLYLINE, 1, 3 * U, -U, 5, 1);
		send_vertex(21, SHAPE_FREEHAND, 1, 7 * U, U, 0, 0);
		send_vertex(21, SHAPE_FREEHAND, 1, 8 * U, -U, 0, 1);
		send_vertex(22, SHAPE_RECT, 1, U, 3 * U, 0, 0);
		send_vertex(22, SHAPE_RECT, 1, -U, 3 * U, 0, 0);
		send_vertex(22, SHAPE_RECT, 1, -U, -3 * U, 0, 1);
		send_finish();
		// one-point polygon, shape change inside an annotation, tie keeps earlier id
		send_vertex(30, SHAPE_POLYGON, 1, 0, 0, 0, 1);
		send_vertex(0, SHAPE_POINT, 1, 0, U, 0, 1);
		send_vertex(31, SHAPE_POINT, 1, U, 0, 0, 1);
		send_vertex(32, SHAPE_POINT, 1, 9 * U, 0, 0, 0);
		send_vertex(32, SHAPE_POLYGON, 1, 0, -U / 4, 0, 1);
		send_vertex(33, SHAPE_LINE, 1, 0, 0, 0, 0);
		send_finish();
		send_finish();
		wait_idle();
		// extreme coordinates saturate the distance
		set_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, DIST_NONE);
		send_vertex(40, SHAPE_POINT, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
		send_vertex(41, SHAPE_CIRCLE, 1, 32'h7FFF_FFFF, 0, 0, 1, DIST_NONE);
		send_vertex(42, SHAPE_POLYGON, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
		send_vertex(42, SHAPE_POLYGON, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
		send_finish();
		wait_idle();
		set_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send_vertex(43, SHAPE_POINT, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
		send_finish();
		wait_idle();
	endtask

	task automatic test_backpressure();
		set_query(0, 0, 0, 100 * U);
		hold_req = 1'b1;
		for (int i = 0; i < 5; i++) begin
			send_vertex(60 + i, SHAPE_POINT, 1, i * U, U, 0, 1);
			send_finish();
		end
		wait_idle();
	endtask

	function automatic logic [31:0] near_coord(word_t q, bit wide_range);
		if (wide_range)
			return $urandom;
		return q[31:0] + $urandom_range(0, 32 * U) - 16 * U;
	endfunction

	task automatic test_random(int n_items);
		logic [31:0] id, rad;
		logic [2:0] shape;
		logic vis;
		bit wide_range;
		int nv, n_ann, stop_at;
		stop_at = n_sent + n_items;
		id = 1;
		while (n_sent < stop_at) begin
			if ($urandom_range(0, 5) == 0) begin
				wait_idle();
				if ($urandom_range(0, 9) == 0)
					set_query($urandom, $urandom, $urandom, $urandom);
				else
					set_query($urandom_range(0, 64 * U) - 32 * U,
						$urandom_range(0, 64 * U) - 32 * U,
						$urandom_range(0, 64 * U) - 32 * U, $urandom_range(U, 24 * U));
			end
			n_ann = $urandom_range(1, 6);
			for (int a = 0; a < n_ann; a++) begin
				id = ($urandom_range(0, 19) == 0) ? $urandom : id + $urandom_range(1, 1000);
				shape = $urandom;
				vis = $urandom_range(0, 7) != 0;
				wide_range = $urandom_range(0, 15) == 0;
				rad = wide_range ? $urandom : $urandom_range(0, 8 * U);
				nv = (shape <= SHAPE_TEXT && $urandom_range(0, 3) != 0) ? 1 :
					$urandom_range(1, 5);
				for (int v = 0; v < nv; v++) begin
					if ($urandom_range(0, 29) == 0)
						shape = $urandom;
					if ($urandom_range(0, 59) == 0)
						send_finish();
					send_item(OP_VERTEX, id, shape, rad, vis, near_coord(qry[0], wide_range),
						near_coord(qry[1], wide_range), near_coord(qry[2], wide_range),
						v == nv - 1);
				end
			end
			send_finish();
		end
		wait_idle();
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_left, stall_left;
		hold_left = 0;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready = 1'b0;
			end else if (sink_stall_en && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 3);
				m_tready = 1'b0;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		report_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				$error("report with none outstanding: %h", m_tdata);
				n_errors++;
			end else begin
				exp_r = pending_reports.pop_front();
				n_reports++;
				if (exp_r.hit)
					n_hits++;
				if (m_tdata[0] !== exp_r.hit) begin
					$error("hit_found: expected %0d, got %0d", exp_r.hit, m_tdata[0]);
					n_errors++;
				end
				if (m_tdata[32:1] !== exp_r.id) begin
					$error("best_id: expected %h, got %h", exp_r.id, m_tdata[32:1]);
					n_errors++;
				end
				if (m_tdata[64:33] !== exp_r.distance) begin
					$error("best_distance: expected %h, got %h", exp_r.distance,
						m_tdata[64:33]);
					n_errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		hold_req = 1'b0;
		src_gap_en = 1'b1;
		sink_stall_en = 1'b1;
		n_sent = 0;
		n_reports = 0;
		n_errors = 0;
		n_hits = 0;
		foreach (qry[k]) begin
			qry[k] = '0;
			first_v[k] = '0;
			prev_v[k] = '0;
		end
		tol = '0;
		vcount = '0;
		ann_min = DIST_NONE;
		lead_distance = DIST_NONE;
		best_id = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		test_shapes();
		test_backpressure();
		test_random(960);
		src_gap_en = 1'b0;
		sink_stall_en = 1'b0;
		test_random(150);

		$display("covered all shapes, open cases, extreme coordinates and long back-pressure");
		$display("%0d items sent, %0d reports checked, %0d with a hit",
			n_sent, n_reports, n_hits);
		if (n_errors == 0 && pending_reports.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
rtl/core/aht_pkg.sv
rtl/core/aht_dp.sv
rtl/core/aht_ctrl.sv
rtl/core/annotation_hit_test_core.sv
sim/tb_annotation_hit_test_core.sv
